@@ hdl/lkvc_pkg.sv @@
package lkvc_pkg;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_DEC,
    ST_UPD,
    ST_FIN
  } state_e;

  // register byte addresses
  localparam logic [1:0] ADDR_CAPACITY = 2'd0;

  localparam int unsigned CAP_W      = 11;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

endpackage

@@ hdl/lru_key_value_cache.sv @@
// LRU key/value cache.
// Request channel: start_i with req_type_i (0 get, 1 set), lookup_key_i and
// write_value_i; a word is taken at a clock edge where start_i is high and
// busy_o is low. busy_o stays high while a request is being worked on.
// Result channel: valid_o is high for exactly one cycle with hit_o,
// read_value_o and evicted_o; the receiver cannot stall it.
// Config: APB port, capacity_limit at byte address 0 (11 bits, reset 1024,
// values above MAX_ENTRIES act as MAX_ENTRIES).
// Sequence: a search pass reads one stored key per cycle over all held
// entries; a decide step follows, then a rank pass rewrites one recency
// rank per cycle over count or count + 1 entries in the same way, then the
// result. A get miss skips the rank pass, as does a set with zero capacity
// on an empty cache. busy_o is still high in the result cycle, so the next
// request is taken in the cycle after it at the earliest. The pass speed is
// set by the single read port of the key and rank memories.
// Reset empties the cache (entry count zero) and sets capacity to 1024; the
// memories themselves are not cleared, only held entries are ever read.
module lru_key_value_cache #(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  req_type_i,
  input  logic [KEY_WIDTH-1:0]  lookup_key_i,
  input  logic [VALUE_WIDTH-1:0] write_value_i,
  // result
  output logic                  valid_o,
  output logic                  hit_o,
  output logic [VALUE_WIDTH-1:0] read_value_o,
  output logic                  evicted_o,
  // config
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [1:0]            paddr,
  input  logic [lkvc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lkvc_pkg::APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  lkvc_pkg::state_e state_q, state_d;

  logic [lkvc_pkg::CAP_W-1:0] cap_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] eff_cap;

  // request word
  logic                   is_set_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] val_q;

  // pass sequencing
  logic [CW-1:0] issue_q, issue_d;
  logic [CW-1:0] lim_q, lim_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] pend_idx_q, pend_idx_d;
  logic          pass_done;

  // search captures
  logic                   found_q, found_d;
  logic [AW-1:0]          found_idx_q, found_idx_d;
  logic [AW-1:0]          found_rank_q, found_rank_d;
  logic [VALUE_WIDTH-1:0] found_val_q, found_val_d;
  logic                   lru_ok_q, lru_ok_d;
  logic [AW-1:0]          lru_idx_q, lru_idx_d;

  // rank pass
  logic [AW-1:0] slot_q, slot_d;
  logic [CW-1:0] limit_q, limit_d;

  // result
  logic                   hit_q, hit_d;
  logic                   ev_q, ev_d;
  logic [VALUE_WIDTH-1:0] rd_q, rd_d;

  // memory ports
  logic [AW-1:0]          raddr;
  logic [KEY_WIDTH-1:0]   key_rd;
  logic [VALUE_WIDTH-1:0] val_rd;
  logic [AW-1:0]          rank_rd;
  logic                   kv_we;
  logic [AW-1:0]          kv_waddr;
  logic                   key_we;
  logic                   rank_we;
  logic [AW-1:0]          rank_wdata;
  logic [CW-1:0]          rank_inc;

  logic accept;
  logic cfg_wr;

  assign accept = start_i && (state_q == lkvc_pkg::ST_IDLE);
  assign cfg_wr = psel && penable && pwrite && (paddr == lkvc_pkg::ADDR_CAPACITY);

  // effective capacity saturates at MAX_ENTRIES
  assign eff_cap = (32'(cap_q) > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(cap_q);

  // APB
  assign pready = 1'b1;
  assign prdata = (paddr == lkvc_pkg::ADDR_CAPACITY)
                ? lkvc_pkg::APB_DATA_W'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkvc_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      cap_q <= pwdata[lkvc_pkg::CAP_W-1:0];
    end
  end

  // memories
  lkvc_ram #(.W(KEY_WIDTH), .DEPTH(MAX_ENTRIES), .AW(AW)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (kv_waddr),
    .wdata_i (key_q),
    .raddr_i (raddr),
    .rdata_o (key_rd)
  );

  lkvc_ram #(.W(VALUE_WIDTH), .DEPTH(MAX_ENTRIES), .AW(AW)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (kv_we),
    .waddr_i (kv_waddr),
    .wdata_i (val_q),
    .raddr_i (raddr),
    .rdata_o (val_rd)
  );

  lkvc_ram #(.W(AW), .DEPTH(MAX_ENTRIES), .AW(AW)) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (pend_idx_q),
    .wdata_i (rank_wdata),
    .raddr_i (raddr),
    .rdata_o (rank_rd)
  );

  assign raddr     = issue_q[AW-1:0];
  assign pass_done = (issue_q == lim_q) && !pend_q;
  assign rank_inc  = CW'(rank_rd) + CW'(1);
  assign rank_wdata = (pend_idx_q == slot_q)        ? '0 :
                      (CW'(rank_rd) < limit_q)       ? rank_inc[AW-1:0] : rank_rd;
  assign rank_we   = (state_q == lkvc_pkg::ST_UPD) && pend_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lkvc_pkg::ST_IDLE: if (accept) state_d = lkvc_pkg::ST_SRCH;
      lkvc_pkg::ST_SRCH: if (pass_done) state_d = lkvc_pkg::ST_DEC;
      lkvc_pkg::ST_DEC: begin
        if (!found_q && (!is_set_q || ((count_q >= eff_cap) && (count_q == '0)))) begin
          state_d = lkvc_pkg::ST_FIN;
        end else begin
          state_d = lkvc_pkg::ST_UPD;
        end
      end
      lkvc_pkg::ST_UPD: if (pass_done) state_d = lkvc_pkg::ST_FIN;
      lkvc_pkg::ST_FIN: state_d = lkvc_pkg::ST_IDLE;
      default: state_d = lkvc_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    issue_d      = issue_q;
    lim_d        = lim_q;
    pend_d       = 1'b0;
    pend_idx_d   = issue_q[AW-1:0];
    found_d      = found_q;
    found_idx_d  = found_idx_q;
    found_rank_d = found_rank_q;
    found_val_d  = found_val_q;
    lru_ok_d     = lru_ok_q;
    lru_idx_d    = lru_idx_q;
    slot_d       = slot_q;
    limit_d      = limit_q;
    count_d      = count_q;
    hit_d        = hit_q;
    ev_d         = ev_q;
    rd_d         = rd_q;
    kv_we        = 1'b0;
    key_we       = 1'b0;
    kv_waddr     = slot_q;

    unique case (state_q) inside
      lkvc_pkg::ST_IDLE: begin
        issue_d  = '0;
        lim_d    = count_q;
        found_d  = 1'b0;
        lru_ok_d = 1'b0;
      end
      lkvc_pkg::ST_SRCH, lkvc_pkg::ST_UPD: begin
        // issue one read per cycle
        if (issue_q != lim_q) begin
          pend_d  = 1'b1;
          issue_d = issue_q + CW'(1);
        end
        // check the word read last cycle
        if (state_q == lkvc_pkg::ST_SRCH && pend_q) begin
          if (!found_q && key_rd == key_q) begin
            found_d      = 1'b1;
            found_idx_d  = pend_idx_q;
            found_rank_d = rank_rd;
            found_val_d  = val_rd;
          end
          if (!lru_ok_q && CW'(rank_rd) == count_q - CW'(1)) begin
            lru_ok_d  = 1'b1;
            lru_idx_d = pend_idx_q;
          end
        end
      end
      lkvc_pkg::ST_DEC: begin
        issue_d = '0;
        hit_d   = found_q;
        ev_d    = 1'b0;
        rd_d    = '0;
        lim_d   = count_q;
        if (found_q) begin
          slot_d   = found_idx_q;
          limit_d  = CW'(found_rank_q);
          kv_waddr = found_idx_q;
          kv_we    = is_set_q;
          if (!is_set_q) rd_d = found_val_q;
        end else if (is_set_q) begin
          if (count_q >= eff_cap) begin
            // full: least recent slot takes the new entry (nothing is stored when empty)
            ev_d     = 1'b1;
            slot_d   = lru_idx_q;
            limit_d  = count_q;
            kv_waddr = lru_idx_q;
            kv_we    = (count_q != '0);
            key_we   = (count_q != '0);
          end else begin
            // append at the end
            slot_d   = count_q[AW-1:0];
            limit_d  = count_q + CW'(1);
            lim_d    = count_q + CW'(1);
            count_d  = count_q + CW'(1);
            kv_waddr = count_q[AW-1:0];
            kv_we    = 1'b1;
            key_we   = 1'b1;
          end
        end
      end
      lkvc_pkg::ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lkvc_pkg::ST_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
      issue_q <= '0;
      lim_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      issue_q <= issue_d;
      lim_q   <= lim_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      is_set_q <= req_type_i;
      key_q    <= lookup_key_i;
      val_q    <= write_value_i;
    end
    pend_idx_q   <= pend_idx_d;
    found_q      <= found_d;
    found_idx_q  <= found_idx_d;
    found_rank_q <= found_rank_d;
    found_val_q  <= found_val_d;
    lru_ok_q     <= lru_ok_d;
    lru_idx_q    <= lru_idx_d;
    slot_q       <= slot_d;
    limit_q      <= limit_d;
    hit_q        <= hit_d;
    ev_q         <= ev_d;
    rd_q         <= rd_d;
  end

  // outputs
  assign busy_o       = (state_q != lkvc_pkg::ST_IDLE);
  assign valid_o      = (state_q == lkvc_pkg::ST_FIN);
  assign hit_o        = hit_q;
  assign evicted_o    = ev_q;
  assign read_value_o = rd_q;

  // checks
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(hit_o && evicted_o))
    else $error("hit and eviction in one result");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(MAX_ENTRIES))
    else $error("entry count above MAX_ENTRIES");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !hit_o) |-> (read_value_o == '0))
    else $error("nonzero read value on a miss");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == $past(count_q) + CW'(1)))
    else $error("entry count moved by more than one");

endmodule

@@ hdl/lkvc_ram.sv @@
module lkvc_ram #(
  parameter int unsigned W     = 32,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ test/lru_key_value_cache_tb.sv @@
module lru_key_value_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = 1024;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef enum logic {REQ_GET = 1'b0, REQ_SET = 1'b1} req_e;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
  } lookup_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        req_type_i = 1'b0;
  logic [31:0] lookup_key_i = '0;
  logic [31:0] write_value_i = '0;
  logic        valid_o;
  logic        hit_o;
  logic [31:0] read_value_o;
  logic        evicted_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [lkvc_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [lkvc_pkg::APB_DATA_W-1:0] prdata;
  logic        pready;

  lru_key_value_cache dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_type_i, .lookup_key_i, .write_value_i,
    .valid_o, .hit_o, .read_value_o, .evicted_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #10 clk_i = ~clk_i;

  // predictor copy of the cache contents
  logic [31:0] cache_key [SLOTS];
  logic [31:0] cache_val [SLOTS];
  int unsigned cache_rank [SLOTS];
  int unsigned cache_count = 0;
  int unsigned cache_cap = 1024;

  lookup_result_t expected_results[$];
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned hits_seen = 0;
  int unsigned evictions_seen = 0;
  int unsigned idle_cycles = 0;
  bit          idling_on = 1'b1;
  int unsigned activity = 0;
  int unsigned activity_seen = 0;

  // entries more recent than lim age by one, slot becomes most recent
  function automatic void age_and_promote(int unsigned slot, int unsigned lim);
    for (int unsigned j = 0; j < cache_count; j++) begin
      if (j != slot && cache_rank[j] < lim) cache_rank[j]++;
    end
    cache_rank[slot] = 0;
  endfunction

  function automatic lookup_result_t predict_lookup(req_e op, logic [31:0] key,
                                                    logic [31:0] val);
    lookup_result_t r;
    int unsigned eff_cap;
    int unsigned found;
    int unsigned lru;
    int unsigned s;
    r = '0;
    found = 0;
    eff_cap = (cache_cap > SLOTS) ? SLOTS : cache_cap;
    for (int unsigned i = 0; i < cache_count; i++) begin
      if (cache_key[i] == key) begin
        found = i;
        r.hit = 1'b1;
        break;
      end
    end
    if (r.hit) begin
      if (op == REQ_SET) cache_val[found] = val;
      else r.read_value = cache_val[found];
      age_and_promote(found, cache_rank[found]);
    end else if (op == REQ_SET) begin
      if (cache_count + 1 > eff_cap) begin
        r.evicted = 1'b1;
        if (cache_count > 0) begin
          // least recent slot is reused for the new entry
          lru = 0;
          for (int unsigned i = 0; i < cache_count; i++) begin
            if (cache_rank[i] == cache_count - 1) begin
              lru = i;
              break;
            end
          end
          cache_key[lru] = key;
          cache_val[lru] = val;
          age_and_promote(lru, cache_count);
        end
      end else begin
        s = cache_count;
        cache_count++;
        cache_key[s] = key;
        cache_val[s] = val;
        cache_rank[s] = cache_count;
        age_and_promote(s, cache_count);
      end
    end
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    lookup_result_t exp_r;
    if (rst_ni && valid_o) begin
      activity++;
      words_checked++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word hit=%0b", hit_o);
      end else begin
        exp_r = expected_results.pop_front();
        if (hit_o !== exp_r.hit || read_value_o !== exp_r.read_value ||
            evicted_o !== exp_r.evicted) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit=%0b val=%h ev=%0b, got hit=%0b val=%h ev=%0b",
                     exp_r.hit, exp_r.read_value, exp_r.evicted,
                     hit_o, read_value_o, evicted_o);
        end
        if (exp_r.hit) hits_seen++;
        if (exp_r.evicted) evictions_seen++;
      end
    end
  end

  // watchdog on cycles without any accepted word, result or capacity write
  always @(posedge clk_i) begin
    if (activity != activity_seen) begin
      activity_seen = activity;
      idle_cycles = 0;
    end else if (++idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // send one request word, optional idle gap afterwards
  task automatic send_word(req_e op, logic [31:0] key, logic [31:0] val);
    lookup_result_t r;
    @(negedge clk_i);
    start_i = 1'b1;
    req_type_i = op;
    lookup_key_i = key;
    write_value_i = val;
    do @(posedge clk_i); while (busy_o);
    r = predict_lookup(op, key, val);
    expected_results = {expected_results, r};
    activity++;
    words_sent++;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      start_i = 1'b0;
      req_type_i = 1'($urandom);
      lookup_key_i = $urandom;
      write_value_i = $urandom;
      repeat ($urandom_range(0, 10)) @(negedge clk_i);
    end
  endtask

  // stop requesting and wait until every result is back
  task automatic drain;
    @(negedge clk_i);
    start_i = 1'b0;
    while (expected_results.size() != 0 || busy_o) @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [10:0] cap);
    drain();
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = lkvc_pkg::ADDR_CAPACITY;
    pwdata = {21'd0, cap};
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    cache_cap = 32'(cap);
    activity++;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic test_reset_value;
    @(negedge clk_i);
    psel = 1'b1;
    paddr = lkvc_pkg::ADDR_CAPACITY;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    if (prdata[lkvc_pkg::CAP_W-1:0] !== lkvc_pkg::CAP_RESET) begin
      mismatches++;
      $display("capacity after reset: exp %0d got %0d", lkvc_pkg::CAP_RESET, prdata);
    end
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // zero capacity on an empty cache: the new entry is itself evicted
  task automatic test_zero_capacity_empty;
    write_capacity(11'd0);
    send_word(REQ_SET, 32'h1234_5678, 32'hDEAD_BEEF);
    send_word(REQ_GET, 32'h1234_5678, 32'h0);
  endtask

  task automatic test_directed;
    write_capacity(11'd2047);
    send_word(REQ_GET, 32'h0, 32'h0);
    send_word(REQ_SET, 32'h0, 32'h0);
    send_word(REQ_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(REQ_GET, 32'h0, 32'hFFFF_FFFF);
    send_word(REQ_GET, 32'hFFFF_FFFF, 32'h0);
    send_word(REQ_SET, 32'h0, 32'hA5A5_5A5A);
    send_word(REQ_GET, 32'h0, 32'h0);
    send_word(REQ_SET, 32'h5555_5555, 32'h1111_1111);
    // capacity below held count: each set miss replaces the least recent
    write_capacity(11'd2);
    send_word(REQ_SET, 32'hAAAA_AAAA, 32'h2222_2222);
    send_word(REQ_GET, 32'hFFFF_FFFF, 32'h0);
    send_word(REQ_GET, 32'h5555_5555, 32'h0);
    send_word(REQ_SET, 32'h0000_0001, 32'h3333_3333);
    // zero capacity with entries held
    write_capacity(11'd0);
    send_word(REQ_SET, 32'h8000_0000, 32'h8000_0000);
    send_word(REQ_GET, 32'h8000_0000, 32'h0);
    send_word(REQ_GET, 32'h0000_0001, 32'h0);
    write_capacity(11'd1);
    send_word(REQ_SET, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word(REQ_SET, 32'h7FFF_FFFF, 32'h0);
    send_word(REQ_GET, 32'h7FFF_FFFF, 32'h0);
  endtask

  // random phases over a small key pool so hits and evictions are frequent
  task automatic test_random;
    logic [10:0] caps [8] = '{11'd1024, 11'd3, 11'd16, 11'd1, 11'd0, 11'd2047, 11'd8, 11'd5};
    logic [31:0] pool [24];
    logic [31:0] k;
    req_e op;
    foreach (pool[i]) pool[i] = $urandom;
    for (int p = 0; p < 8; p++) begin
      write_capacity(caps[p]);
      idling_on = (p < 6);
      for (int n = 0; n < 34; n++) begin
        op = req_e'($urandom_range(0, 1));
        if ($urandom_range(0, 7) == 0) k = $urandom;
        else k = pool[$urandom_range(0, 23)];
        send_word(op, k, $urandom);
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_value();
    test_zero_capacity_empty();
    test_directed();
    test_random();
    drain();
    repeat (2100) @(posedge clk_i);
    $display("sent %0d request words, checked %0d results (%0d hits, %0d evictions)",
             words_sent, words_checked, hits_seen, evictions_seen);
    $display("capacities swept from 0 to 2047, final held entries %0d", cache_count);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
